/* rtl/sgpg_pkg.sv */
// Package for the scaled glyph pixel generator: cell geometry, register indexes
// and the 5x7 font ROM with its lookup function. Depends on nothing.
`default_nettype none

package sgpg_pkg;

  localparam int CELL_W   = 6;
  localparam int CELL_H   = 8;
  localparam int GLY_COLS = 5;
  localparam int GLY_ROWS = 7;

  localparam int CODE_W  = 8;
  localparam int COORD_W = 5;
  localparam int COLOR_W = 16;
  localparam int SCALE_W = 2;
  localparam int GC_W    = 3;
  localparam int GR_W    = 3;

  localparam logic [15:0]        FG_RESET    = 16'hFFFF;
  localparam logic [15:0]        BG_RESET    = 16'h0000;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 2'd1;

  typedef enum logic [1:0] {
    REG_FOREGROUND = 2'd0,
    REG_BACKGROUND = 2'd1,
    REG_SCALE      = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_reg_t;

  localparam int NUM_GLYPHS = 66;
  localparam int GIDX_W     = 7;

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;

  localparam int BASE_DIGIT = 26;
  localparam int BASE_UPPER = 36;
  localparam int BASE_SYM   = 62;

  // Each word holds the five column bytes, column 0 in the top byte.
  // Bit r of a column byte is glyph row r.
  localparam logic [39:0] FONT [NUM_GLYPHS] = '{
    40'h2054545478, 40'h7F48443800, 40'h3844444400, 40'h3844487F00,
    40'h3854541800, 40'h087E090100, 40'h0C52523E00, 40'h7F08047800,
    40'h00447D4000, 40'h2040443D00, 40'h7F10284400, 40'h00417F4000,
    40'h7C04180478, 40'h7C08047800, 40'h3844443800, 40'h7C14140800,
    40'h0814147C00, 40'h7C08040000, 40'h4854542400, 40'h043F440000,
    40'h3C40207C00, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844,
    40'h0C50503C00, 40'h4464544C44,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E,
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
    40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
    40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
    40'h3E4151215E, 40'h7F09192946, 40'h2649494932, 40'h01017F0101,
    40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543,
    40'h08083E0808, 40'h0808080808, 40'h0036360000, 40'h14083E0814
  };

  // Column byte (rows 0..6) of the glyph for a code; blank where no glyph exists.
  function automatic logic [GLY_ROWS-1:0] font_col(input logic [CODE_W-1:0] code,
                                                    input logic [GC_W-1:0] col);
    logic [GIDX_W-1:0] idx;
    logic              hit;
    logic [39:0]       word;
    logic [7:0]        colb;
    idx  = '0;
    hit  = 1'b1;
    colb = '0;
    priority if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
      idx = GIDX_W'(code - CHAR_LOWER_A);
    end else if (code >= CHAR_DIGIT_0 && code <= CHAR_DIGIT_9) begin
      idx = GIDX_W'(code - CHAR_DIGIT_0) + GIDX_W'(BASE_DIGIT);
    end else if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
      idx = GIDX_W'(code - CHAR_UPPER_A) + GIDX_W'(BASE_UPPER);
    end else if (code == CHAR_PLUS) begin
      idx = GIDX_W'(BASE_SYM);
    end else if (code == CHAR_MINUS) begin
      idx = GIDX_W'(BASE_SYM + 1);
    end else if (code == CHAR_COLON) begin
      idx = GIDX_W'(BASE_SYM + 2);
    end else if (code == CHAR_STAR) begin
      idx = GIDX_W'(BASE_SYM + 3);
    end else begin
      hit = 1'b0;
    end
    word = FONT[idx];
    case (col)
      3'd0:    colb = word[39:32];
      3'd1:    colb = word[31:24];
      3'd2:    colb = word[23:16];
      3'd3:    colb = word[15:8];
      3'd4:    colb = word[7:0];
      default: colb = '0;
    endcase
    return hit ? colb[GLY_ROWS-1:0] : '0;
  endfunction

endpackage

`default_nettype wire

/* rtl/sgpg_in_if.sv */
// Request channel of the scaled glyph pixel generator: valid, ready and the
// character code with the pixel coordinates. Depends on sgpg_pkg.
`default_nettype none

interface sgpg_in_if;
  import sgpg_pkg::*;

  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  char_code;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;

  modport source (output valid, output char_code, output pixel_x, output pixel_y,
                  input ready);
  modport sink   (input valid, input char_code, input pixel_x, input pixel_y,
                  output ready);
endinterface

`default_nettype wire

/* rtl/sgpg_out_if.sv */
// Result channel of the scaled glyph pixel generator: valid, ready, the pixel
// colour and the outside-cell flag. Depends on sgpg_pkg.
`default_nettype none

interface sgpg_out_if;
  import sgpg_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic               outside_cell;

  modport source (output valid, output pixel_color, output outside_cell, input ready);
  modport sink   (input valid, input pixel_color, input outside_cell, output ready);
endinterface

`default_nettype wire

/* rtl/scaled_glyph_pixel_generator_top.sv */
// Top level of the scaled glyph pixel generator: configuration registers and a
// three-stage pipeline (scale and divide, font ROM, colour select).
// Depends on sgpg_pkg, sgpg_in_if and sgpg_out_if.
// An accepted request passes through the stage 1, stage 2 and stage 3 registers to the output.
// Throughput: one request per clock while the output is taken; each stage holds while the next one stalls.
// Reset (synchronous, rst_n low) empties the pipeline and loads the register defaults.
`default_nettype none

module scaled_glyph_pixel_generator_top #(
  parameter int MAX_SCALE = 3
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  sgpg_in_if.sink                       in_chan,
  sgpg_out_if.source                    out_chan,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [15:0]              cfg_wdata
);
  import sgpg_pkg::*;

  logic [COLOR_W-1:0] fg_r;
  logic [COLOR_W-1:0] bg_r;
  logic [SCALE_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r    <= FG_RESET;
      bg_r    <= BG_RESET;
      scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FOREGROUND: fg_r    <= cfg_wdata;
        REG_BACKGROUND: bg_r    <= cfg_wdata;
        REG_SCALE:      scale_r <= cfg_wdata[SCALE_W-1:0];
        REG_UNUSED:     ;
      endcase
    end
  end

  // Stage 1: effective scale, cell bounds and division down to glyph coordinates.
  logic [SCALE_W-1:0] scale_eff;
  logic [5:0]         lim_x;
  logic [5:0]         lim_y;
  logic [8:0]         prod_x;
  logic [8:0]         prod_y;
  logic [COORD_W-1:0] qx;
  logic [COORD_W-1:0] qy;
  logic [GC_W-1:0]    gc1_nxt;
  logic [GR_W-1:0]    gr1_nxt;
  logic               out1_nxt;

  always_comb begin
    scale_eff = (scale_r == '0) ? SCALE_W'(1) : scale_r;
    if (int'(scale_eff) > MAX_SCALE) begin
      scale_eff = SCALE_W'(MAX_SCALE);
    end
    lim_x    = 6'(CELL_W * int'(scale_eff));
    lim_y    = 6'(CELL_H * int'(scale_eff));
    out1_nxt = ({1'b0, in_chan.pixel_x} >= lim_x) || ({1'b0, in_chan.pixel_y} >= lim_y);
    // Division by three as multiplication by 11/32, exact for values below 32.
    prod_x = 9'(in_chan.pixel_x) * 9'd11;
    prod_y = 9'(in_chan.pixel_y) * 9'd11;
    case (scale_eff)
      2'd2:    begin qx = in_chan.pixel_x >> 1; qy = in_chan.pixel_y >> 1; end
      2'd3:    begin qx = {1'b0, prod_x[8:5]};  qy = {1'b0, prod_y[8:5]};  end
      default: begin qx = in_chan.pixel_x;      qy = in_chan.pixel_y;      end
    endcase
    gc1_nxt = qx[GC_W-1:0];
    gr1_nxt = qy[GR_W-1:0];
  end

  logic              v1_r;
  logic [CODE_W-1:0] cc1_r;
  logic [GC_W-1:0]   gc1_r;
  logic [GR_W-1:0]   gr1_r;
  logic              out1_r;

  // Stage 2: font ROM lookup.
  logic [GLY_ROWS-1:0] colbits;
  logic                lit2_nxt;

  always_comb begin
    colbits  = font_col(cc1_r, gc1_r);
    lit2_nxt = 1'b0;
    if (!out1_r && int'(gc1_r) < GLY_COLS && int'(gr1_r) < GLY_ROWS) begin
      lit2_nxt = colbits[gr1_r];
    end
  end

  logic v2_r;
  logic lit2_r;
  logic out2_r;

  // Stage 3: colour selection into the output register.
  logic [COLOR_W-1:0] color3_nxt;
  assign color3_nxt = lit2_r ? fg_r : bg_r;

  logic               v3_r;
  logic [COLOR_W-1:0] color3_r;
  logic               out3_r;

  logic rdy1;
  logic rdy2;
  logic rdy3;

  assign rdy3          = !v3_r || out_chan.ready;
  assign rdy2          = !v2_r || rdy3;
  assign rdy1          = !v1_r || rdy2;
  assign in_chan.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_chan.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      cc1_r  <= in_chan.char_code;
      gc1_r  <= gc1_nxt;
      gr1_r  <= gr1_nxt;
      out1_r <= out1_nxt;
    end
    if (rdy2) begin
      lit2_r <= lit2_nxt;
      out2_r <= out1_r;
    end
    if (rdy3) begin
      color3_r <= color3_nxt;
      out3_r   <= out2_r;
    end
  end

  assign out_chan.valid        = v3_r;
  assign out_chan.pixel_color  = color3_r;
  assign out_chan.outside_cell = out3_r;

  a_in_cell_col : assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !out1_r |-> int'(gc1_r) <= GLY_COLS)
    else $error("glyph column beyond the cell for an inside pixel");

  a_outside_dark : assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && out2_r |-> !lit2_r)
    else $error("pixel outside the cell marked as lit");

  a_stage2_hold : assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !rdy3 |=> v2_r && $stable(lit2_r) && $stable(out2_r))
    else $error("stage two changed while stalled");

  a_out_from_stage2 : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v3_r) |-> $past(v2_r))
    else $error("result appeared without a request in stage two");

endmodule

`default_nettype wire
